/* rtl/token_lexer_unit_macros.svh */
// ----------------------------------------------------------------------------
// token_lexer_unit assertion macros
// Shared concurrent assertion forms for the lexer RTL.
// ----------------------------------------------------------------------------
`ifndef TOKEN_LEXER_UNIT_MACROS_SVH
`define TOKEN_LEXER_UNIT_MACROS_SVH

// same-cycle implication
`define TLEX_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("token lexer assertion failed");

// next-cycle implication
`define TLEX_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("token lexer assertion failed");

`endif

/* rtl/tlex_pkg.sv */
// ----------------------------------------------------------------------------
// tlex_pkg
// Token kinds, keyword tracking codes and byte classes for the lexer.
// ----------------------------------------------------------------------------
package tlex_pkg;

  localparam int OFFSET_BITS_DEF   = 16;
  localparam int MAX_TOKEN_LEN_DEF = 255;
  localparam int Q_DEPTH           = 4;

  localparam logic [7:0] SKIP_LOW  = 8'd32;
  localparam logic [7:0] SKIP_HIGH = 8'd127;

  typedef enum logic [3:0] {
    KIND_INT     = 4'd0,
    KIND_IDENT   = 4'd1,
    KIND_PLUS    = 4'd2,
    KIND_MINUS   = 4'd3,
    KIND_STAR    = 4'd4,
    KIND_LPAREN  = 4'd5,
    KIND_RPAREN  = 4'd6,
    KIND_LBRACE  = 4'd7,
    KIND_RBRACE  = 4'd8,
    KIND_EQUALS  = 4'd9,
    KIND_SLASH   = 4'd10,
    KIND_SEMI    = 4'd11,
    KIND_END     = 4'd12,
    KIND_IF      = 4'd13,
    KIND_ELSE    = 4'd14,
    KIND_UNKNOWN = 4'd15
  } kind_t;

  // prefix progress toward "if" / "else"
  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_I    = 3'd1;
  localparam logic [2:0] KW_IF   = 3'd2;
  localparam logic [2:0] KW_E    = 3'd3;
  localparam logic [2:0] KW_EL   = 3'd4;
  localparam logic [2:0] KW_ELS  = 3'd5;
  localparam logic [2:0] KW_ELSE = 3'd6;

  typedef struct packed {
    logic       letter;
    logic       digit;
    logic       skip;
    logic       sym;
    kind_t      sym_kind;
    logic [2:0] kw_first;
  } cls_t;

  function automatic logic [2:0] track_next(input logic [2:0] t, input logic [7:0] b);
    logic [2:0] r;
    r = KW_NONE;
    if (t == KW_I && b == "f") r = KW_IF;
    else if (t == KW_E && b == "l") r = KW_EL;
    else if (t == KW_EL && b == "s") r = KW_ELS;
    else if (t == KW_ELS && b == "e") r = KW_ELSE;
    return r;
  endfunction

endpackage

/* rtl/tlex_classify.sv */
// ----------------------------------------------------------------------------
// tlex_classify
// Byte classifier: letter, digit, skip, symbol kind, keyword first step.
// ----------------------------------------------------------------------------
module tlex_classify (
  input  logic [7:0]    data_byte,
  output tlex_pkg::cls_t cls
);
  import tlex_pkg::*;

  always_comb begin
    cls.letter = (data_byte >= "a" && data_byte <= "z") ||
                 (data_byte >= "A" && data_byte <= "Z") || data_byte == "_";
    cls.digit  = data_byte >= "0" && data_byte <= "9";
    cls.skip   = data_byte <= SKIP_LOW || data_byte >= SKIP_HIGH;
    cls.sym    = 1'b1;
    unique case (data_byte)
      "+":     cls.sym_kind = KIND_PLUS;
      "-":     cls.sym_kind = KIND_MINUS;
      "*":     cls.sym_kind = KIND_STAR;
      "(":     cls.sym_kind = KIND_LPAREN;
      ")":     cls.sym_kind = KIND_RPAREN;
      "{":     cls.sym_kind = KIND_LBRACE;
      "}":     cls.sym_kind = KIND_RBRACE;
      "=":     cls.sym_kind = KIND_EQUALS;
      "/":     cls.sym_kind = KIND_SLASH;
      ";":     cls.sym_kind = KIND_SEMI;
      default: begin
        cls.sym_kind = KIND_UNKNOWN;
        cls.sym      = 1'b0;
      end
    endcase
    if (data_byte == "i") cls.kw_first = KW_I;
    else if (data_byte == "e") cls.kw_first = KW_E;
    else cls.kw_first = KW_NONE;
  end

endmodule

/* rtl/tlex_core.sv */
// ----------------------------------------------------------------------------
// tlex_core
// Lexer state and token update; yields up to two results per transaction.
// ----------------------------------------------------------------------------
`include "token_lexer_unit_macros.svh"

module tlex_core #(
  parameter int OFFSET_BITS   = tlex_pkg::OFFSET_BITS_DEF,
  parameter int MAX_TOKEN_LEN = tlex_pkg::MAX_TOKEN_LEN_DEF,
  parameter int LEN_BITS      = $clog2(MAX_TOKEN_LEN + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_input,
  input  tlex_pkg::cls_t         cls,
  output logic [1:0]             res_count,
  output tlex_pkg::kind_t        res_kind  [2],
  output logic [OFFSET_BITS-1:0] res_start [2],
  output logic [LEN_BITS-1:0]    res_length[2],
  output logic                   res_last  [2]
);
  import tlex_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_INT   = 2'd2,
    MODE_ERROR = 2'd3
  } mode_t;

  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_TOKEN_LEN);
  localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] pending_start, pending_start_next;
  logic [LEN_BITS-1:0]    pending_length, pending_length_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [2:0]             keyword_track, keyword_track_next;

  logic                   pend, va, vb;
  kind_t                  a_kind, b_kind;
  logic [OFFSET_BITS-1:0] b_start;
  logic [LEN_BITS-1:0]    b_len, grown;

  always_comb begin
    pend  = mode == MODE_IDENT || mode == MODE_INT;
    grown = (pending_length < LEN_MAX) ? pending_length + LEN_ONE : pending_length;
    if (mode == MODE_IDENT) begin
      if (keyword_track == KW_IF) a_kind = KIND_IF;
      else if (keyword_track == KW_ELSE) a_kind = KIND_ELSE;
      else a_kind = KIND_IDENT;
    end else begin
      a_kind = KIND_INT;
    end

    mode_next           = mode;
    pending_start_next  = pending_start;
    pending_length_next = pending_length;
    byte_position_next  = byte_position;
    keyword_track_next  = keyword_track;
    va      = 1'b0;
    vb      = 1'b0;
    b_kind  = KIND_END;
    b_start = byte_position;
    b_len   = '0;

    if (go) begin
      if (end_of_input) begin
        if (mode != MODE_ERROR) begin
          va = pend;
          vb = 1'b1;
        end
        mode_next           = MODE_IDLE;
        pending_start_next  = '0;
        pending_length_next = '0;
        byte_position_next  = '0;
        keyword_track_next  = KW_NONE;
      end else begin
        byte_position_next = byte_position + OFFSET_BITS'(1);
        priority if (mode == MODE_ERROR) begin
          mode_next = MODE_ERROR;
        end else if (mode == MODE_IDENT && (cls.letter || cls.digit)) begin
          pending_length_next = grown;
          keyword_track_next  = track_next(keyword_track, data_byte);
        end else if (mode == MODE_INT && cls.digit) begin
          pending_length_next = grown;
        end else begin
          va                  = pend;
          mode_next           = MODE_IDLE;
          keyword_track_next  = KW_NONE;
          if (pend) pending_length_next = '0;
          priority if (cls.letter) begin
            mode_next           = MODE_IDENT;
            pending_start_next  = byte_position;
            pending_length_next = LEN_ONE;
            keyword_track_next  = cls.kw_first;
          end else if (cls.digit) begin
            mode_next           = MODE_INT;
            pending_start_next  = byte_position;
            pending_length_next = LEN_ONE;
          end else if (cls.skip) begin
            mode_next = MODE_IDLE;
          end else if (cls.sym) begin
            vb     = 1'b1;
            b_kind = cls.sym_kind;
            b_len  = LEN_ONE;
          end else begin
            vb                  = 1'b1;
            b_kind              = KIND_UNKNOWN;
            b_len               = LEN_ONE;
            mode_next           = MODE_ERROR;
            pending_length_next = '0;
          end
        end
      end
    end

    // compact: flushed token first, then the byte's own result
    res_count     = {1'b0, va} + {1'b0, vb};
    res_kind[0]   = va ? a_kind : b_kind;
    res_start[0]  = va ? pending_start : b_start;
    res_length[0] = va ? pending_length : b_len;
    res_last[0]   = !(va && vb);
    res_kind[1]   = b_kind;
    res_start[1]  = b_start;
    res_length[1] = b_len;
    res_last[1]   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      pending_start  <= '0;
      pending_length <= '0;
      byte_position  <= '0;
      keyword_track  <= KW_NONE;
    end else begin
      mode           <= mode_next;
      pending_start  <= pending_start_next;
      pending_length <= pending_length_next;
      byte_position  <= byte_position_next;
      keyword_track  <= keyword_track_next;
    end
  end

  `TLEX_ASSERT_IMPL(a_err_silent, clk, rst, go && !end_of_input && mode == MODE_ERROR, res_count == 2'd0)
  `TLEX_ASSERT_NEXT(a_eoi_clear, clk, rst, go && end_of_input, byte_position == '0 && mode == MODE_IDLE && pending_length == '0)
  `TLEX_ASSERT_IMPL(a_kw_ident, clk, rst, keyword_track != KW_NONE, mode == MODE_IDENT)

endmodule

/* rtl/tlex_result_queue.sv */
// ----------------------------------------------------------------------------
// tlex_result_queue
// Small result queue: takes up to two results per cycle, delivers one unless out_stall.
// ----------------------------------------------------------------------------
`include "token_lexer_unit_macros.svh"

module tlex_result_queue #(
  parameter int OFFSET_BITS = tlex_pkg::OFFSET_BITS_DEF,
  parameter int LEN_BITS    = 8,
  parameter int DEPTH       = tlex_pkg::Q_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             push_count,
  input  tlex_pkg::kind_t        push_kind  [2],
  input  logic [OFFSET_BITS-1:0] push_start [2],
  input  logic [LEN_BITS-1:0]    push_length[2],
  input  logic                   push_last  [2],
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tlex_pkg::kind_t        token_kind,
  output logic [OFFSET_BITS-1:0] token_start,
  output logic [LEN_BITS-1:0]    token_length,
  output logic                   last_of_run
);
  import tlex_pkg::*;

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  kind_t                  q_kind  [DEPTH];
  logic [OFFSET_BITS-1:0] q_start [DEPTH];
  logic [LEN_BITS-1:0]    q_length[DEPTH];
  logic                   q_last  [DEPTH];

  logic [PTR_BITS-1:0] wr_ptr, rd_ptr, wr_ptr_p1;
  logic [CNT_BITS-1:0] count;
  logic                pop;

  assign wr_ptr_p1    = wr_ptr + PTR_BITS'(1);
  assign pop          = out_valid && !out_stall;
  assign out_valid    = count != '0;
  assign room         = count <= CNT_BITS'(DEPTH - 2);
  assign token_kind   = q_kind[rd_ptr];
  assign token_start  = q_start[rd_ptr];
  assign token_length = q_length[rd_ptr];
  assign last_of_run  = q_last[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      q_kind[wr_ptr]   <= push_kind[0];
      q_start[wr_ptr]  <= push_start[0];
      q_length[wr_ptr] <= push_length[0];
      q_last[wr_ptr]   <= push_last[0];
    end
    if (push_count == 2'd2) begin
      q_kind[wr_ptr_p1]   <= push_kind[1];
      q_start[wr_ptr_p1]  <= push_start[1];
      q_length[wr_ptr_p1] <= push_length[1];
      q_last[wr_ptr_p1]   <= push_last[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_count);
      if (pop) rd_ptr <= rd_ptr + PTR_BITS'(1);
      count <= count + CNT_BITS'(push_count) - CNT_BITS'(pop);
    end
  end

  `TLEX_ASSERT_IMPL(a_push_room, clk, rst, push_count != 2'd0, room)
  `TLEX_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_BITS'(DEPTH))
  `TLEX_ASSERT_NEXT(a_hold_stalled, clk, rst, out_valid && out_stall, out_valid)

endmodule

/* rtl/token_lexer_unit.sv */
// An accepted input is registered, then its results are written into the result queue.
// One input per cycle while in_stall is low; the output drains one result per cycle
//   unless out_stall; a byte that closes a token and also forms one yields two results.
// in_stall rises when a registered input waits and the 4-entry queue holds more than two.
// Reset (rst, synchronous): lexer idle at offset zero, queue empty.
// ----------------------------------------------------------------------------
// token_lexer_unit
// Byte-serial tokenizer: identifiers, integers, symbols, if/else keywords, end, unknown.
// ----------------------------------------------------------------------------
module token_lexer_unit #(
  parameter int OFFSET_BITS   = tlex_pkg::OFFSET_BITS_DEF,
  parameter int MAX_TOKEN_LEN = tlex_pkg::MAX_TOKEN_LEN_DEF,
  parameter int LEN_BITS      = $clog2(MAX_TOKEN_LEN + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_input,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tlex_pkg::kind_t        token_kind,
  output logic [OFFSET_BITS-1:0] token_start,
  output logic [LEN_BITS-1:0]    token_length,
  output logic                   last_of_run
);
  import tlex_pkg::*;

  logic       in_valid_r, eoi_r, room, go;
  logic [7:0] byte_r;
  cls_t       cls;

  logic [1:0]             res_count;
  kind_t                  res_kind  [2];
  logic [OFFSET_BITS-1:0] res_start [2];
  logic [LEN_BITS-1:0]    res_length[2];
  logic                   res_last  [2];

  assign go       = in_valid_r && room;
  assign in_stall = in_valid_r && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= data_byte;
      eoi_r  <= end_of_input;
    end
  end

  tlex_classify u_classify (
    .data_byte(byte_r),
    .cls      (cls)
  );

  tlex_core #(
    .OFFSET_BITS  (OFFSET_BITS),
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .LEN_BITS     (LEN_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .data_byte   (byte_r),
    .end_of_input(eoi_r),
    .cls         (cls),
    .res_count   (res_count),
    .res_kind    (res_kind),
    .res_start   (res_start),
    .res_length  (res_length),
    .res_last    (res_last)
  );

  tlex_result_queue #(
    .OFFSET_BITS(OFFSET_BITS),
    .LEN_BITS   (LEN_BITS),
    .DEPTH      (Q_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (res_count),
    .push_kind   (res_kind),
    .push_start  (res_start),
    .push_length (res_length),
    .push_last   (res_last),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .token_start (token_start),
    .token_length(token_length),
    .last_of_run (last_of_run)
  );

endmodule
